// ----- rtl/core/gcsp_pkg.sv -----
package gcsp_pkg;

    // Largest frame side and largest number of stripe bits.
    localparam logic [12:0] MAX_DIM  = 13'd4096;
    localparam logic [3:0]  MAX_BITS = 4'd12;

    localparam logic [7:0] PIX_WHITE = 8'd255;
    localparam logic [7:0] PIX_BLACK = 8'd0;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_DIRECTION_MODE  = 3'd2;
    localparam logic [2:0] REG_ADD_INVERSE     = 3'd3;
    localparam logic [2:0] REG_HORIZONTAL_BITS = 3'd4;
    localparam logic [2:0] REG_VERTICAL_BITS   = 3'd5;

    // Direction modes. The reserved mode acts like both directions.
    localparam logic [1:0] DIR_HORIZONTAL = 2'd0;
    localparam logic [1:0] DIR_VERTICAL   = 2'd1;
    localparam logic [1:0] DIR_BOTH       = 2'd2;
    localparam logic [1:0] DIR_RESERVED   = 2'd3;

    typedef enum logic [1:0] {
        STAGE_H     = 2'd0,
        STAGE_V     = 2'd1,
        STAGE_WHITE = 2'd2,
        STAGE_BLACK = 2'd3
    } stage_t;

    // Configuration as seen by the sequencer, already clamped to legal ranges.
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [3:0]  h_bits;
        logic [3:0]  v_bits;
        logic        h_en;
        logic        v_en;
        logic        add_inverse;
    } eff_cfg_t;

    typedef struct packed {
        logic       sequence_done;
        logic       pattern_done;
        logic [5:0] pattern_number;
        logic [11:0] line;
        logic [11:0] column;
        logic [7:0] pixel_value;
    } pix_item_t;

endpackage

// ----- rtl/core/gray_code_stripe_pattern_generator.sv -----
// Channel   Direction  Ports              Payload
// input     in         s_tvalid/s_tready  s_tdata[0] restart
// result    out        m_tvalid/m_tready  m_tdata pixel/column/line/pattern, tlast, tuser
// config    in/out     APB psel/penable   six registers at byte address 4*i
//
// One pixel item is presented for every input item, in the cycle after it is accepted; the
// sequencer and pixel logic sit between the state registers and one output register.
// An item can be accepted in every cycle while the output register is empty or drains.
// Reset is synchronous and active low; it clears the sequence to its first pixel and
// loads the register defaults. A stall on m_tready holds the output and drops s_tready.
module gray_code_stripe_pattern_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] pixel_value, [19:8] column, [31:20] line,
                                   // [37:32] pattern_number, [39:38] zero
    output logic        m_tlast,   // pattern_done
    output logic        m_tuser,   // sequence_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gcsp_pkg::eff_cfg_t  eff_cfg;
    gcsp_pkg::pix_item_t item;

    logic        accept;
    logic        m_valid_reg;
    logic [39:0] m_data_reg;
    logic        m_last_reg;
    logic        m_user_reg;

    gcsp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eff_cfg (eff_cfg)
    );

    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    gcsp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .eff_cfg (eff_cfg),
        .advance (accept),
        .restart (s_tdata[0]),
        .item    (item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {2'd0, item.pattern_number, item.line, item.column,
                           item.pixel_value};
            m_last_reg <= item.pattern_done;
            m_user_reg <= item.sequence_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_seq_done_ends_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("sequence end without pattern end");

    a_pixel_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255))
        else $error("pixel value is neither black nor white");

    a_restart_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[0] |=> m_tvalid && (m_tdata[37:8] == 30'd0))
        else $error("restart item did not start at the first pixel");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

endmodule

// ----- rtl/core/gcsp_cfg.sv -----
module gcsp_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output gcsp_pkg::eff_cfg_t   eff_cfg
);

    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [1:0]  direction_mode_reg;
    logic        add_inverse_reg;
    logic [3:0]  horizontal_bits_reg;
    logic [3:0]  vertical_bits_reg;

    logic [2:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg     <= 13'd1024;
            frame_height_reg    <= 13'd768;
            direction_mode_reg  <= gcsp_pkg::DIR_BOTH;
            add_inverse_reg     <= 1'b1;
            horizontal_bits_reg <= 4'd10;
            vertical_bits_reg   <= 4'd10;
        end else if (wr_en) begin
            unique case (reg_index)
                gcsp_pkg::REG_FRAME_WIDTH:     frame_width_reg     <= pwdata[12:0];
                gcsp_pkg::REG_FRAME_HEIGHT:    frame_height_reg    <= pwdata[12:0];
                gcsp_pkg::REG_DIRECTION_MODE:  direction_mode_reg  <= pwdata[1:0];
                gcsp_pkg::REG_ADD_INVERSE:     add_inverse_reg     <= pwdata[0];
                gcsp_pkg::REG_HORIZONTAL_BITS: horizontal_bits_reg <= pwdata[3:0];
                gcsp_pkg::REG_VERTICAL_BITS:   vertical_bits_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            gcsp_pkg::REG_FRAME_WIDTH:     prdata = {19'd0, frame_width_reg};
            gcsp_pkg::REG_FRAME_HEIGHT:    prdata = {19'd0, frame_height_reg};
            gcsp_pkg::REG_DIRECTION_MODE:  prdata = {30'd0, direction_mode_reg};
            gcsp_pkg::REG_ADD_INVERSE:     prdata = {31'd0, add_inverse_reg};
            gcsp_pkg::REG_HORIZONTAL_BITS: prdata = {28'd0, horizontal_bits_reg};
            gcsp_pkg::REG_VERTICAL_BITS:   prdata = {28'd0, vertical_bits_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // Sizes of zero act as one, oversized values saturate.
    always_comb begin
        if (frame_width_reg == 13'd0) begin
            eff_cfg.width = 13'd1;
        end else if (frame_width_reg > gcsp_pkg::MAX_DIM) begin
            eff_cfg.width = gcsp_pkg::MAX_DIM;
        end else begin
            eff_cfg.width = frame_width_reg;
        end
        if (frame_height_reg == 13'd0) begin
            eff_cfg.height = 13'd1;
        end else if (frame_height_reg > gcsp_pkg::MAX_DIM) begin
            eff_cfg.height = gcsp_pkg::MAX_DIM;
        end else begin
            eff_cfg.height = frame_height_reg;
        end
        eff_cfg.h_bits = (horizontal_bits_reg > gcsp_pkg::MAX_BITS) ?
                         gcsp_pkg::MAX_BITS : horizontal_bits_reg;
        eff_cfg.v_bits = (vertical_bits_reg > gcsp_pkg::MAX_BITS) ?
                         gcsp_pkg::MAX_BITS : vertical_bits_reg;
        // Mode three behaves like both directions.
        eff_cfg.h_en = (direction_mode_reg != gcsp_pkg::DIR_VERTICAL) &&
                       (eff_cfg.h_bits != 4'd0);
        eff_cfg.v_en = (direction_mode_reg != gcsp_pkg::DIR_HORIZONTAL) &&
                       (eff_cfg.v_bits != 4'd0);
        eff_cfg.add_inverse = add_inverse_reg;
    end

endmodule

// ----- rtl/core/gcsp_pixel.sv -----
module gcsp_pixel (
    input  gcsp_pkg::stage_t stage,
    input  logic [11:0]      column,
    input  logic [11:0]      line,
    input  logic [3:0]       bit_index,
    input  logic             inverse,
    output logic [7:0]       pixel_value
);

    logic [11:0] coord;
    logic [15:0] gray;
    logic        stripe;

    always_comb begin
        coord  = (stage == gcsp_pkg::STAGE_H) ? column : line;
        gray   = {4'd0, coord ^ (coord >> 1)};
        stripe = gray[bit_index] ^ inverse;
        unique case (stage)
            gcsp_pkg::STAGE_WHITE: pixel_value = gcsp_pkg::PIX_WHITE;
            gcsp_pkg::STAGE_BLACK: pixel_value = gcsp_pkg::PIX_BLACK;
            default:               pixel_value = stripe ? gcsp_pkg::PIX_WHITE
                                                        : gcsp_pkg::PIX_BLACK;
        endcase
    end

endmodule

// ----- rtl/core/gcsp_seq.sv -----
module gcsp_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gcsp_pkg::eff_cfg_t   eff_cfg,
    input  logic                 advance,
    input  logic                 restart,
    output gcsp_pkg::pix_item_t  item
);

    logic [11:0]      col_reg, col_next;
    logic [11:0]      line_reg, line_next;
    gcsp_pkg::stage_t stage_reg, stage_next;
    logic [3:0]       bit_reg, bit_next;
    logic             inv_reg, inv_next;
    logic [5:0]       pat_reg, pat_next;

    logic [11:0]      cur_col;
    logic [11:0]      cur_line;
    gcsp_pkg::stage_t cur_stage;
    logic [3:0]       cur_bit;
    logic             cur_inv;
    logic [5:0]       cur_pat;

    gcsp_pkg::stage_t first_stage;
    logic [12:0]      col_plus;
    logic [12:0]      line_plus;
    logic             end_col;
    logic             end_line;
    logic [4:0]       bit_plus;
    logic [3:0]       bit_limit;
    logic [7:0]       pixel_value;

    always_comb begin
        if (eff_cfg.h_en) begin
            first_stage = gcsp_pkg::STAGE_H;
        end else if (eff_cfg.v_en) begin
            first_stage = gcsp_pkg::STAGE_V;
        end else begin
            first_stage = gcsp_pkg::STAGE_WHITE;
        end
    end

    // A restart item is itself the first pixel of the new sequence.
    always_comb begin
        if (restart) begin
            cur_col   = 12'd0;
            cur_line  = 12'd0;
            cur_stage = first_stage;
            cur_bit   = 4'd0;
            cur_inv   = 1'b0;
            cur_pat   = 6'd0;
        end else begin
            cur_col   = col_reg;
            cur_line  = line_reg;
            cur_stage = stage_reg;
            cur_bit   = bit_reg;
            cur_inv   = inv_reg;
            cur_pat   = pat_reg;
        end
    end

    gcsp_pixel u_pixel (
        .stage       (cur_stage),
        .column      (cur_col),
        .line        (cur_line),
        .bit_index   (cur_bit),
        .inverse     (cur_inv),
        .pixel_value (pixel_value)
    );

    // Ends are found with ">=" so a frame that shrank mid-pattern ends at once.
    assign col_plus  = {1'b0, cur_col} + 13'd1;
    assign line_plus = {1'b0, cur_line} + 13'd1;
    assign end_col   = col_plus >= eff_cfg.width;
    assign end_line  = line_plus >= eff_cfg.height;
    assign bit_plus  = {1'b0, cur_bit} + 5'd1;
    assign bit_limit = (cur_stage == gcsp_pkg::STAGE_H) ? eff_cfg.h_bits : eff_cfg.v_bits;

    always_comb begin
        item.pixel_value    = pixel_value;
        item.column         = cur_col;
        item.line           = cur_line;
        item.pattern_number = cur_pat;
        item.pattern_done   = end_col && end_line;
        item.sequence_done  = end_col && end_line && (cur_stage == gcsp_pkg::STAGE_BLACK);
    end

    always_comb begin
        col_next   = cur_col;
        line_next  = cur_line;
        stage_next = cur_stage;
        bit_next   = cur_bit;
        inv_next   = cur_inv;
        pat_next   = cur_pat;
        if (!end_col) begin
            col_next = col_plus[11:0];
        end else begin
            col_next = 12'd0;
            if (!end_line) begin
                line_next = line_plus[11:0];
            end else begin
                line_next = 12'd0;
                if (cur_stage == gcsp_pkg::STAGE_BLACK) begin
                    stage_next = first_stage;
                    bit_next   = 4'd0;
                    inv_next   = 1'b0;
                    pat_next   = 6'd0;
                end else begin
                    pat_next = cur_pat + 6'd1;
                    if (cur_stage == gcsp_pkg::STAGE_WHITE) begin
                        stage_next = gcsp_pkg::STAGE_BLACK;
                    end else if (eff_cfg.add_inverse && !cur_inv) begin
                        inv_next = 1'b1;
                    end else begin
                        inv_next = 1'b0;
                        if (bit_plus < {1'b0, bit_limit}) begin
                            bit_next = bit_plus[3:0];
                        end else begin
                            bit_next = 4'd0;
                            stage_next = (cur_stage == gcsp_pkg::STAGE_H && eff_cfg.v_en) ?
                                         gcsp_pkg::STAGE_V : gcsp_pkg::STAGE_WHITE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= 12'd0;
            line_reg  <= 12'd0;
            // The reset configuration enables horizontal stripes, so they come first.
            stage_reg <= gcsp_pkg::STAGE_H;
            bit_reg   <= 4'd0;
            inv_reg   <= 1'b0;
            pat_reg   <= 6'd0;
        end else if (advance) begin
            col_reg   <= col_next;
            line_reg  <= line_next;
            stage_reg <= stage_next;
            bit_reg   <= bit_next;
            inv_reg   <= inv_next;
            pat_reg   <= pat_next;
        end
    end

endmodule

// ----- sim/tb_gray_code_stripe_pattern_generator.sv -----
`timescale 1ns / 1ps

module tb_gray_code_stripe_pattern_generator;

    // Tracks the stripe sequence alongside the block and checks each pixel item.
    class pixel_scoreboard;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        logic [1:0]  dir_reg;
        logic        inv_reg;
        logic [3:0]  hbits_reg;
        logic [3:0]  vbits_reg;

        logic [11:0] col;
        logic [11:0] row;
        gcsp_pkg::stage_t stage;
        logic [3:0]  bit_idx;
        logic        inv_phase;
        logic [5:0]  pat_idx;

        gcsp_pkg::pix_item_t expected_pixels[$];
        int          errors;

        function new();
            width_reg  = 13'd1024;
            height_reg = 13'd768;
            dir_reg    = gcsp_pkg::DIR_BOTH;
            inv_reg    = 1'b1;
            hbits_reg  = 4'd10;
            vbits_reg  = 4'd10;
            errors     = 0;
            restart_seq();
        endfunction

        function logic [12:0] clamp_size(logic [12:0] v);
            if (v == 13'd0)
                return 13'd1;
            return (v > gcsp_pkg::MAX_DIM) ? gcsp_pkg::MAX_DIM : v;
        endfunction

        function logic [3:0] clamp_bits(logic [3:0] v);
            return (v > gcsp_pkg::MAX_BITS) ? gcsp_pkg::MAX_BITS : v;
        endfunction

        function logic h_on();
            return dir_reg != gcsp_pkg::DIR_VERTICAL && clamp_bits(hbits_reg) != 4'd0;
        endfunction

        function logic v_on();
            return dir_reg != gcsp_pkg::DIR_HORIZONTAL && clamp_bits(vbits_reg) != 4'd0;
        endfunction

        function void restart_seq();
            col       = '0;
            row       = '0;
            bit_idx   = '0;
            inv_phase = 1'b0;
            pat_idx   = '0;
            stage     = h_on() ? gcsp_pkg::STAGE_H
                               : (v_on() ? gcsp_pkg::STAGE_V : gcsp_pkg::STAGE_WHITE);
        endfunction

        function void write_reg(logic [4:0] addr, logic [31:0] data);
            case (addr[4:2])
                gcsp_pkg::REG_FRAME_WIDTH:     width_reg  = data[12:0];
                gcsp_pkg::REG_FRAME_HEIGHT:    height_reg = data[12:0];
                gcsp_pkg::REG_DIRECTION_MODE:  dir_reg    = data[1:0];
                gcsp_pkg::REG_ADD_INVERSE:     inv_reg    = data[0];
                gcsp_pkg::REG_HORIZONTAL_BITS: hbits_reg  = data[3:0];
                gcsp_pkg::REG_VERTICAL_BITS:   vbits_reg  = data[3:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_item(logic restart);
            gcsp_pkg::pix_item_t e;
            logic [12:0] w;
            logic [12:0] h;
            logic [11:0] coord;
            logic [11:0] gray;
            logic        end_col;
            logic        end_row;
            logic [3:0]  limit;

            if (restart)
                restart_seq();
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);

            case (stage)
                gcsp_pkg::STAGE_WHITE: e.pixel_value = gcsp_pkg::PIX_WHITE;
                gcsp_pkg::STAGE_BLACK: e.pixel_value = gcsp_pkg::PIX_BLACK;
                default: begin
                    coord = (stage == gcsp_pkg::STAGE_H) ? col : row;
                    gray  = coord ^ (coord >> 1);
                    e.pixel_value = (((gray >> bit_idx) & 12'd1) != 12'd0) ?
                                    gcsp_pkg::PIX_WHITE : gcsp_pkg::PIX_BLACK;
                    if (inv_phase)
                        e.pixel_value = gcsp_pkg::PIX_WHITE - e.pixel_value;
                end
            endcase

            end_col = ({1'b0, col} + 13'd1) >= w;
            end_row = ({1'b0, row} + 13'd1) >= h;
            e.column         = col;
            e.line           = row;
            e.pattern_number = pat_idx;
            e.pattern_done   = end_col && end_row;
            e.sequence_done  = end_col && end_row && stage == gcsp_pkg::STAGE_BLACK;
            expected_pixels = {expected_pixels, e};

            // Raster advance; the pattern step reads the registers as they are now.
            if (!end_col) begin
                col++;
            end else begin
                col = '0;
                if (!end_row) begin
                    row++;
                end else begin
                    row = '0;
                    if (stage == gcsp_pkg::STAGE_BLACK) begin
                        restart_seq();
                    end else begin
                        pat_idx++;
                        if (stage == gcsp_pkg::STAGE_WHITE) begin
                            stage = gcsp_pkg::STAGE_BLACK;
                        end else if (inv_reg && !inv_phase) begin
                            inv_phase = 1'b1;
                        end else begin
                            inv_phase = 1'b0;
                            limit = (stage == gcsp_pkg::STAGE_H) ? clamp_bits(hbits_reg)
                                                                 : clamp_bits(vbits_reg);
                            if ({1'b0, bit_idx} + 5'd1 < {1'b0, limit}) begin
                                bit_idx++;
                            end else begin
                                bit_idx = '0;
                                stage = (stage == gcsp_pkg::STAGE_H && v_on()) ?
                                        gcsp_pkg::STAGE_V : gcsp_pkg::STAGE_WHITE;
                            end
                        end
                    end
                end
            end
        endfunction

        function void check_pixel(logic [39:0] tdata, logic tlast, logic tuser);
            gcsp_pkg::pix_item_t e;
            gcsp_pkg::pix_item_t got;

            got.pixel_value    = tdata[7:0];
            got.column         = tdata[19:8];
            got.line           = tdata[31:20];
            got.pattern_number = tdata[37:32];
            got.pattern_done   = tlast;
            got.sequence_done  = tuser;

            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel item, got pix=%0d col=%0d line=%0d pat=%0d",
                         $time, got.pixel_value, got.column, got.line, got.pattern_number);
                return;
            end
            e = expected_pixels.pop_front();
            if (got.pixel_value !== e.pixel_value || got.column !== e.column ||
                got.line !== e.line || got.pattern_number !== e.pattern_number ||
                got.pattern_done !== e.pattern_done || got.sequence_done !== e.sequence_done) begin
                errors++;
                $display("%0t: expected pix=%0d col=%0d line=%0d pat=%0d pdone=%0b sdone=%0b",
                         $time, e.pixel_value, e.column, e.line, e.pattern_number,
                         e.pattern_done, e.sequence_done);
                $display("%0t:      got pix=%0d col=%0d line=%0d pat=%0d pdone=%0b sdone=%0b",
                         $time, got.pixel_value, got.column, got.line, got.pattern_number,
                         got.pattern_done, got.sequence_done);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [7:0] pixel_value, [19:8] column, [31:20] line,
                            // [37:32] pattern_number, [39:38] zero
    logic        m_tlast;   // pattern_done
    logic        m_tuser;   // sequence_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pixel_scoreboard sb;
    bit              bursty;
    int              items_taken;
    int              pixels_taken;
    int              writes_done;
    int              random_items;

    gray_code_stripe_pattern_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                sb.write_reg(paddr, pwdata);
                writes_done++;
            end
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tdata[0]);
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                sb.check_pixel(m_tdata, m_tlast, m_tuser);
                pixels_taken++;
            end
        end
    end

    // Result side: a random stall before each item when idling is on.
    initial begin
        int stall;
        int seen;

        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = bursty ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            seen = pixels_taken;
            do @(negedge aclk); while (pixels_taken == seen);
        end
    end

    task automatic send_item(input logic restart);
        int gap;
        int seen;

        gap = bursty ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        seen = items_taken;
        do @(negedge aclk); while (items_taken == seen);
    endtask

    // Restarts come rarely so that whole sequences get through.
    task automatic run_items(input int count, input bit noisy);
        for (int i = 0; i < count; i++)
            send_item(noisy && $urandom_range(0, 49) == 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        int seen;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        seen = writes_done;
        do @(negedge aclk); while (writes_done == seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input logic [12:0] w, input logic [12:0] h, input logic [1:0] dir,
                             input logic inv, input logic [3:0] hb, input logic [3:0] vb);
        write_reg(gcsp_pkg::REG_FRAME_WIDTH, {19'd0, w});
        write_reg(gcsp_pkg::REG_FRAME_HEIGHT, {19'd0, h});
        write_reg(gcsp_pkg::REG_DIRECTION_MODE, {30'd0, dir});
        write_reg(gcsp_pkg::REG_ADD_INVERSE, {31'd0, inv});
        write_reg(gcsp_pkg::REG_HORIZONTAL_BITS, {28'd0, hb});
        write_reg(gcsp_pkg::REG_VERTICAL_BITS, {28'd0, vb});
    endtask

    // Waits until every expected pixel has left the block.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [12:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'($urandom_range(7, 40));
            default: return 13'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [3:0] pick_bits();
        return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    endfunction

    initial begin
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 5'd0;
        pwdata   = 32'd0;
        bursty   = 1'b1;
        items_taken  = 0;
        pixels_taken = 0;
        writes_done  = 0;
        random_items = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default registers straight out of reset.
        run_items(4, 1'b0);
        settle();

        // One pixel per pattern walks through all fifty pattern numbers and wraps.
        write_all(13'd1, 13'd1, gcsp_pkg::DIR_BOTH, 1'b1, 4'd12, 4'd12);
        send_item(1'b1);
        run_items(52, 1'b0);
        send_item(1'b1);
        run_items(3, 1'b0);
        settle();

        // Zero width, mode three and a bit count above the maximum.
        write_all(13'd0, 13'd2, gcsp_pkg::DIR_RESERVED, 1'b0, 4'd1, 4'd14);
        send_item(1'b1);
        run_items(31, 1'b0);
        settle();

        // No stripe stage enabled: only white and black remain.
        write_all(13'd2, 13'd1, gcsp_pkg::DIR_HORIZONTAL, 1'b1, 4'd0, 4'd5);
        send_item(1'b1);
        run_items(5, 1'b0);
        settle();

        // Oversize width saturates, then the width shrinks below the current column.
        write_all(13'd8191, 13'd1, gcsp_pkg::DIR_HORIZONTAL, 1'b1, 4'd15, 4'd0);
        send_item(1'b1);
        run_items(300, 1'b0);
        settle();
        write_reg(gcsp_pkg::REG_FRAME_WIDTH, 32'd5);
        run_items(12, 1'b0);
        settle();

        // Vertical stripes only, through a whole sequence and into the next.
        write_all(13'd0, 13'd16, gcsp_pkg::DIR_VERTICAL, 1'b0, 4'd3, 4'd12);
        send_item(1'b1);
        run_items(230, 1'b0);
        settle();

        // Random phases; registers change between them while the counters carry on.
        while (random_items < 720) begin
            int n;

            if ($urandom_range(0, 1))
                write_reg(gcsp_pkg::REG_FRAME_WIDTH, {19'd0, pick_size()});
            if ($urandom_range(0, 1))
                write_reg(gcsp_pkg::REG_FRAME_HEIGHT, {19'd0, pick_size()});
            if ($urandom_range(0, 1))
                write_reg(gcsp_pkg::REG_DIRECTION_MODE, 32'($urandom_range(0, 3)));
            if ($urandom_range(0, 1))
                write_reg(gcsp_pkg::REG_ADD_INVERSE, 32'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                write_reg(gcsp_pkg::REG_HORIZONTAL_BITS, {28'd0, pick_bits()});
            if ($urandom_range(0, 1))
                write_reg(gcsp_pkg::REG_VERTICAL_BITS, {28'd0, pick_bits()});
            bursty = $urandom_range(0, 3) != 0;
            n = $urandom_range(20, 120);
            if ($urandom_range(0, 3) == 0) begin
                send_item(1'b1);
                n--;
            end
            run_items(n, 1'b1);
            random_items += n + 1;
            settle();
        end

        repeat (4) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
